/* hw/rtl/oneshot_timer_bank_core_macros.svh */
// ============================================================================
// oneshot_timer_bank_core_macros.svh
// Assertion helper macros for the one-shot timer bank.
// ============================================================================
`ifndef ONESHOT_TIMER_BANK_CORE_MACROS_SVH
`define ONESHOT_TIMER_BANK_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OTB_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OTB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OTB_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg)
`define OTB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)

`endif

`endif

/* hw/rtl/otb_pkg.sv */
// ============================================================================
// otb_pkg
// Shared types and constants for the one-shot timer bank.
// ============================================================================
package otb_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int TICK_WIDTH_DEF = 32;

    localparam int FIELD_W    = 32;
    localparam int IDX_W      = 4;
    localparam int SLOT_MAX_W = 8;
    localparam int CFG_W      = 32;

    localparam logic [CFG_W-1:0] COLLECT_TIMEOUT_RST = 32'd10000;

    typedef enum logic [1:0] {
        OP_SCAN,
        OP_ALLOC,
        OP_ARM,
        OP_RELEASE
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_SLOT,
        ST_BUSY,
        ST_FULL
    } status_t;

    typedef enum logic {
        CFG_COLLECT_ENABLE,
        CFG_COLLECT_TIMEOUT
    } cfg_idx_t;

    // datapath -> slot tracker, applied when go is high
    typedef struct packed {
        logic             go;
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic             visit_free;
    } trk_req_t;

    // slot tracker -> datapath
    typedef struct packed {
        logic                  idx_used;
        logic                  visit_used;
        logic [SLOT_MAX_W-1:0] visit_slot;
        logic                  free_found;
        logic [SLOT_MAX_W-1:0] free_slot;
        logic                  pend_valid;
        logic                  pend_live;
    } trk_stat_t;

endpackage

/* hw/rtl/otb_slot_mem.sv */
// ============================================================================
// otb_slot_mem
// Slot record memory: one write port, one read port, registered read data.
// ============================================================================
module otb_slot_mem
    import otb_pkg::*;
#(
    parameter int DEPTH = SLOT_COUNT_DEF,
    parameter int WIDTH = 1 + 2 * TICK_WIDTH_DEF + FIELD_W
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/otb_slot_track.sv */
// ============================================================================
// otb_slot_track
// Slot occupancy flags, round-robin scan pointer and the pending release.
// ============================================================================
module otb_slot_track
    import otb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  trk_req_t  req,
    output trk_stat_t stat
);

    localparam int SW = $clog2(SLOT_COUNT);

    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [SW-1:0]         ptr_reg, ptr_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [SW-1:0]         pend_slot_reg, pend_slot_next;

    logic                  idx_in_range;
    logic [SW-1:0]         idx_sw;
    logic                  idx_used;
    logic                  free_found;
    logic [SW-1:0]         free_slot;
    logic [SLOT_COUNT-1:0] used_after;
    logic                  next_found;
    logic [SW-1:0]         next_slot;

    assign idx_in_range = (int'(req.idx) < SLOT_COUNT);
    assign idx_sw       = SW'(req.idx);
    assign idx_used     = idx_in_range && used_reg[idx_sw];

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    // occupancy after this scan's collection and pending release
    always_comb
    begin
        used_after = used_reg;
        if (req.visit_free)
        begin
            used_after[ptr_reg] = 1'b0;
        end
        if (pend_valid_reg)
        begin
            used_after[pend_slot_reg] = 1'b0;
        end
    end

    // next used slot after the pointer, wrapping
    always_comb
    begin
        int cw;
        next_found = 1'b0;
        next_slot  = '0;
        for (int k = SLOT_COUNT; k >= 1; k--)
        begin
            cw = int'(ptr_reg) + k;
            if (cw >= SLOT_COUNT)
            begin
                cw = cw - SLOT_COUNT;
            end
            if (used_after[cw])
            begin
                next_found = 1'b1;
                next_slot  = SW'(cw);
            end
        end
    end

    always_comb
    begin
        used_next       = used_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        if (req.go)
        begin
            case (req.op)
                OP_ALLOC:
                begin
                    if (free_found)
                    begin
                        used_next[free_slot] = 1'b1;
                    end
                end
                OP_RELEASE:
                begin
                    if (idx_used && !pend_valid_reg)
                    begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_sw;
                    end
                end
                OP_SCAN:
                begin
                    used_next       = used_after;
                    pend_valid_next = 1'b0;
                    if (next_found)
                    begin
                        ptr_next = next_slot;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
        end
        else
        begin
            used_reg       <= used_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            pend_slot_reg  <= pend_slot_next;
        end
    end

    assign stat.idx_used   = idx_used;
    assign stat.visit_used = used_reg[ptr_reg];
    assign stat.visit_slot = SLOT_MAX_W'(ptr_reg);
    assign stat.free_found = free_found;
    assign stat.free_slot  = SLOT_MAX_W'(free_slot);
    assign stat.pend_valid = pend_valid_reg;
    assign stat.pend_live  = pend_valid_reg && used_reg[pend_slot_reg];

endmodule

/* hw/rtl/oneshot_timer_bank_core.sv */
// ============================================================================
// oneshot_timer_bank_core
// Bank of one-shot timer slots with round-robin expiry scan.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries opcode, now_tick, slot_index,
//   timeout and payload. Opcodes: scan step, allocate, arm, release request.
//   Every item yields exactly one result on the output channel
//   (out_valid / out_stall): status, result_slot, fired, fired_payload,
//   reclaimed.
//   The slot record is read on accept and written back on completion, so a
//   new item is accepted only when the execute stage is empty. A result is
//   registered in the output register once that register can take it.
//   in_stall is high while an item sits in the execute stage.
//   If out_stall holds a result, one more item is accepted and waits in the
//   execute stage with its record already read; nothing is written until its
//   result can be registered.
//   Reset: all slots free, scan pointer 0, no pending release,
//   collect_enable 1, collect_timeout 10000. Slot records need no clearing.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 collect_enable, 1 collect_timeout); write only while idle.
// ============================================================================
`include "oneshot_timer_bank_core_macros.svh"

module oneshot_timer_bank_core
    import otb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [FIELD_W-1:0] now_tick,
    input  logic [IDX_W-1:0]   slot_index,
    input  logic [FIELD_W-1:0] timeout,
    input  logic [FIELD_W-1:0] payload,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [IDX_W-1:0]   result_slot,
    output logic               fired,
    output logic [FIELD_W-1:0] fired_payload,
    output logic               reclaimed,

    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int TW    = TICK_WIDTH;
    localparam int REC_W = 1 + 2 * TW + FIELD_W;

    // config
    logic             collect_enable_reg;
    logic [CFG_W-1:0] collect_timeout_reg;

    // execute stage
    logic               s1_valid_reg, s1_valid_next;
    op_t                s1_op_reg;
    logic [FIELD_W-1:0] s1_now_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [FIELD_W-1:0] s1_timeout_reg;
    logic [FIELD_W-1:0] s1_payload_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg;
    logic [IDX_W-1:0]   result_slot_reg;
    logic               fired_reg;
    logic [FIELD_W-1:0] fired_payload_reg;
    logic               reclaimed_reg;

    logic in_accept;
    logic s1_done;

    logic [SW-1:0]    rd_addr;
    logic [REC_W-1:0] rd_data;
    logic             mem_we;
    logic             mem_wr_en;
    logic [SW-1:0]    wr_addr;
    logic [REC_W-1:0] wr_data;

    trk_req_t  trk_req;
    trk_stat_t trk_stat;

    logic               rec_armed;
    logic [TW-1:0]      rec_deadline;
    logic [TW-1:0]      rec_reclaim;
    logic [FIELD_W-1:0] rec_payload;
    logic [TW-1:0]      now_t;
    logic [TW-1:0]      arm_deadline;
    logic [TW-1:0]      reclaim_dl;

    status_t            res_status;
    logic [IDX_W-1:0]   res_slot;
    logic               res_fired;
    logic [FIELD_W-1:0] res_fpay;
    logic               res_recl;
    logic               visit_free;

    assign in_accept = in_valid && !s1_valid_reg;
    assign in_stall  = s1_valid_reg;
    assign s1_done   = s1_valid_reg && (!out_valid_reg || !out_stall);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collect_enable_reg  <= 1'b1;
            collect_timeout_reg <= COLLECT_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLLECT_ENABLE:  collect_enable_reg  <= cfg_data[0];
                CFG_COLLECT_TIMEOUT: collect_timeout_reg <= cfg_data;
                default:             collect_enable_reg  <= collect_enable_reg;
            endcase
        end
    end

    // record read address on accept
    assign rd_addr = (op_t'(opcode) == OP_SCAN) ? trk_stat.visit_slot[SW-1:0]
                                                : SW'(slot_index);

    otb_slot_mem #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (REC_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign trk_req.go         = s1_done;
    assign trk_req.op         = s1_op_reg;
    assign trk_req.idx        = s1_idx_reg;
    assign trk_req.visit_free = visit_free;

    otb_slot_track #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (trk_req),
        .stat  (trk_stat)
    );

    // record layout: armed | deadline | reclaim deadline | payload
    assign rec_armed    = rd_data[REC_W-1];
    assign rec_deadline = rd_data[REC_W-2 -: TW];
    assign rec_reclaim  = rd_data[FIELD_W+TW-1 -: TW];
    assign rec_payload  = rd_data[FIELD_W-1:0];

    assign now_t        = TW'(s1_now_reg);
    assign arm_deadline = now_t + TW'(s1_timeout_reg);
    assign reclaim_dl   = now_t + TW'(collect_timeout_reg);

    always_comb
    begin
        res_status = ST_OK;
        res_slot   = '0;
        res_fired  = 1'b0;
        res_fpay   = '0;
        res_recl   = 1'b0;
        visit_free = 1'b0;
        mem_we     = 1'b0;
        wr_addr    = SW'(s1_idx_reg);
        wr_data    = rd_data;
        case (s1_op_reg)
            OP_ALLOC:
            begin
                if (trk_stat.free_found)
                begin
                    res_slot = IDX_W'(trk_stat.free_slot);
                    mem_we   = 1'b1;
                    wr_addr  = trk_stat.free_slot[SW-1:0];
                    wr_data  = {1'b0, {TW{1'b0}}, reclaim_dl, {FIELD_W{1'b0}}};
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            OP_ARM:
            begin
                res_slot = s1_idx_reg;
                if (!trk_stat.idx_used)
                begin
                    res_status = ST_BAD_SLOT;
                end
                else
                begin
                    mem_we  = 1'b1;
                    wr_data = {1'b1, arm_deadline, reclaim_dl, s1_payload_reg};
                end
            end
            OP_RELEASE:
            begin
                res_slot = s1_idx_reg;
                if (!trk_stat.idx_used)
                begin
                    res_status = ST_BAD_SLOT;
                end
                else if (trk_stat.pend_valid)
                begin
                    res_status = ST_BUSY;
                end
            end
            OP_SCAN:
            begin
                res_slot = IDX_W'(trk_stat.visit_slot);
                wr_addr  = trk_stat.visit_slot[SW-1:0];
                if (!trk_stat.visit_used)
                begin
                    res_status = ST_BAD_SLOT;
                end
                else if (rec_armed)
                begin
                    if (now_t >= rec_deadline)
                    begin
                        res_fired = 1'b1;
                        res_fpay  = rec_payload;
                        mem_we    = 1'b1;
                        wr_data   = {1'b0, rec_deadline, rec_reclaim, rec_payload};
                    end
                end
                else if (collect_enable_reg && (rec_reclaim <= now_t))
                begin
                    visit_free = 1'b1;
                end
                res_recl = visit_free || trk_stat.pend_live;
            end
            default:
            begin
            end
        endcase
    end

    assign mem_wr_en = mem_we && s1_done;

    // execute stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg      <= op_t'(opcode);
            s1_now_reg     <= now_tick;
            s1_idx_reg     <= slot_index;
            s1_timeout_reg <= timeout;
            s1_payload_reg <= payload;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done)
        begin
            status_reg        <= res_status;
            result_slot_reg   <= res_slot;
            fired_reg         <= res_fired;
            fired_payload_reg <= res_fpay;
            reclaimed_reg     <= res_recl;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_slot   = result_slot_reg;
    assign fired         = fired_reg;
    assign fired_payload = fired_payload_reg;
    assign reclaimed     = reclaimed_reg;

    `OTB_ASSERT_NEXT(a_done_loads_out, clk, rst_n, s1_done, out_valid && !in_stall,
        "completed item did not reach the output register")
    `OTB_ASSERT_IMPL(a_fire_ok, clk, rst_n, out_valid && fired, status == ST_OK,
        "fired item carries an error status")
    `OTB_ASSERT_IMPL(a_full_clean, clk, rst_n, out_valid && status == ST_FULL,
        !fired && !reclaimed && result_slot == '0, "failed allocate has side results")
    `OTB_ASSERT_IMPL(a_fpay_only_fired, clk, rst_n, out_valid && fired_payload != '0, fired,
        "fired payload set without a fire")

endmodule
